// ===== hdl/ssd_pkg.sv =====
// ssd_pkg: types, codes and helpers shared by the stitch stream decoder
// no dependencies; compiled before every other file of the block
package ssd_pkg;

	localparam int MaxColours = 256;
	localparam int CountW     = 31;
	localparam int SinceW     = 32;
	localparam int HeldW      = 24;

	localparam logic ItemLoad = 1'b0;
	localparam logic ItemByte = 1'b1;

	localparam logic [7:0] MarkerByte = 8'h80;
	localparam logic [7:0] CmdEnd     = 8'h03;
	localparam logic [7:0] CmdJumpOff = 8'h02;
	localparam logic [7:0] CmdTrim    = 8'h01;

	localparam logic [1:0] SkNormal = 2'd0;
	localparam logic [1:0] SkJump   = 2'd1;
	localparam logic [1:0] SkTrim   = 2'd2;
	localparam logic [1:0] SkStop   = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [CountW-1:0] stitch_count;
		logic [7:0]        byte_value;
	} item_t;

	typedef struct packed {
		logic [1:0]         stitch_kind;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic               last;
	} result_t;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_TRIM0,
		PH_TRIM1,
		PH_TRIM2,
		PH_TRIM3
	} phase_t;

	function automatic logic signed [15:0] sext8(input logic [7:0] b);
		return {{8{b[7]}}, b};
	endfunction

endpackage

// ===== hdl/ssd_ram.sv =====
// ssd_ram: generic single-write, single-read ram with registered read data
// no dependencies
module ssd_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/stitch_stream_decoder.sv =====
// stitch_stream_decoder: top level, byte pairing, colour stops, output buffer
// depends on ssd_pkg and ssd_ram
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   item     | item_valid / item_ready   | ssd_pkg::item_t (load or byte)
//   result   | result_valid / result_ready | ssd_pkg::result_t
//
// one item per cycle while item_ready is high; an item that yields a colour stop and a
// stitch fills the output register and a second slot, and the next item waits on that slot
// the count table is read ahead at the next colour index, with a
// write-to-read bypass, so a pair sees its count without extra latency
// reset clears all control state; count table entries are undefined until loaded
// item_ready drops only while the output register is stalled or the second slot is full
module stitch_stream_decoder #(
	parameter int MAX_COLOURS = ssd_pkg::MaxColours
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ssd_pkg::item_t  item,
	input  logic            item_valid,
	output logic            item_ready,
	output ssd_pkg::result_t result,
	output logic            result_valid,
	input  logic            result_ready
);

	import ssd_pkg::*;

	localparam int IW = $clog2(MAX_COLOURS + 1);
	localparam int AW = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;

	logic [IW-1:0]     colours_loaded_q;
	logic [IW-1:0]     colour_index_q;
	logic [IW-1:0]     colour_index_d;
	logic [SinceW-1:0] since_q;
	logic              jump_q;
	phase_t            phase_q;
	phase_t            phase_d;
	logic [HeldW-1:0]  held_q;

	logic              out_valid_q;
	result_t           out_q;
	logic              pend_valid_q;
	result_t           pend_q;

	logic              fwd_hit_q;
	logic [CountW-1:0] fwd_data_q;
	logic [CountW-1:0] count_mem;
	logic [CountW-1:0] count_rd;

	logic              can_load;
	logic              acc;
	logic              is_byte;
	logic              load_wr;
	logic [7:0]        b0;
	logic [7:0]        b1;
	logic              stop_hit;
	logic              marker;
	logic              trim_cmd;
	logic [1:0]        inc;
	logic [SinceW-1:0] since_base;
	logic [SinceW:0]   since_sum;
	logic [SinceW-1:0] since_new;
	result_t           r0;
	result_t           r1;
	result_t           rs;
	logic              r0_v;
	logic              r1_v;

	assign can_load   = !out_valid_q || result_ready;
	assign item_ready = can_load && !pend_valid_q;
	assign acc        = item_valid && item_ready;
	assign is_byte    = acc && (item.kind == ItemByte);
	assign load_wr    = acc && (item.kind == ItemLoad) &&
	                    (colours_loaded_q < IW'(MAX_COLOURS));

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// count table, read ahead at the next colour index
	ssd_ram #(
		.WIDTH(CountW),
		.DEPTH(MAX_COLOURS)
	) u_count_ram (
		.clk  (clk),
		.we   (load_wr),
		.waddr(colours_loaded_q[AW-1:0]),
		.wdata(item.stitch_count),
		.raddr(colour_index_d[AW-1:0]),
		.rdata(count_mem)
	);

	assign count_rd = fwd_hit_q ? fwd_data_q : count_mem;

	always_comb begin
		b0         = held_q[7:0];
		b1         = item.byte_value;
		stop_hit   = (colour_index_q < IW'(MAX_COLOURS)) && (since_q >= {1'b0, count_rd});
		marker     = (b0 == MarkerByte) &&
		             (b1 == CmdEnd || b1 == CmdJumpOff || b1 == CmdTrim);
		trim_cmd   = marker && (b1 == CmdTrim);
		inc        = trim_cmd ? 2'd3 : (((b0 == MarkerByte) && !marker) ? 2'd2 : 2'd1);
		since_base = stop_hit ? '0 : since_q;
		since_sum  = {1'b0, since_base} + (SinceW + 1)'(inc);
		since_new  = since_sum[SinceW] ? '1 : since_sum[SinceW-1:0];
		colour_index_d = colour_index_q +
		                 IW'(is_byte && (phase_q == PH_SECOND) && stop_hit);
	end

	// byte phase next state
	always_comb begin
		phase_d = phase_q;
		if (is_byte) begin
			unique case (phase_q)
				PH_FIRST:  phase_d = PH_SECOND;
				PH_SECOND: phase_d = trim_cmd ? PH_TRIM0 : PH_FIRST;
				PH_TRIM0:  phase_d = PH_TRIM1;
				PH_TRIM1:  phase_d = PH_TRIM2;
				PH_TRIM2:  phase_d = PH_TRIM3;
				PH_TRIM3:  phase_d = PH_FIRST;
				default:   phase_d = PH_FIRST;
			endcase
		end
	end

	// results of the accepted byte
	always_comb begin
		r0   = '0;
		r1   = '0;
		r0_v = 1'b0;
		r1_v = 1'b0;
		rs   = '{stitch_kind: (jump_q ? SkJump : SkNormal),
		         dx: sext8(b0), dy: sext8(b1), last: 1'b1};
		if (is_byte) begin
			unique case (phase_q)
				PH_SECOND: begin
					if (stop_hit) begin
						r0   = '{stitch_kind: SkStop, dx: '0, dy: '0, last: marker};
						r0_v = 1'b1;
						if (!marker) begin
							r1   = rs;
							r1_v = 1'b1;
						end
					end else if (!marker) begin
						r0   = rs;
						r0_v = 1'b1;
					end
				end
				PH_TRIM3: begin
					r0   = '{stitch_kind: SkTrim, dx: held_q[23:8],
					         dy: {held_q[7:0], b1}, last: 1'b1};
					r0_v = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colours_loaded_q <= '0;
			colour_index_q   <= '0;
			since_q          <= '0;
			jump_q           <= 1'b0;
			phase_q          <= PH_FIRST;
			held_q           <= '0;
			fwd_hit_q        <= 1'b0;
		end else begin
			fwd_hit_q      <= load_wr && (colours_loaded_q[AW-1:0] == colour_index_d[AW-1:0]);
			colour_index_q <= colour_index_d;
			phase_q        <= phase_d;
			if (load_wr) begin
				colours_loaded_q <= colours_loaded_q + IW'(1);
			end
			if (is_byte) begin
				unique case (phase_q)
					PH_FIRST: held_q <= {16'd0, b1};
					PH_SECOND: begin
						since_q <= since_new;
						if (marker && (b1 == CmdJumpOff)) begin
							jump_q <= 1'b0;
						end
						if (trim_cmd) begin
							held_q <= '0;
						end
					end
					PH_TRIM3: begin
						jump_q <= 1'b1;
						held_q <= '0;
					end
					default: held_q <= {held_q[15:0], b1};
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= item.stitch_count;
	end

	// output register and second slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (can_load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= r0_v;
				pend_valid_q <= r1_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (r0_v) begin
				out_q <= r0;
			end
		end
		if (r1_v) begin
			pend_q <= r1;
		end
	end

endmodule

// ===== hdl/ssd_checker.sv =====
// ssd_checker: port-level checks on the stitch stream decoder, bound to the top
// depends on ssd_pkg and stitch_stream_decoder
module ssd_checker (
	input logic             clk,
	input logic             arst_n,
	input ssd_pkg::item_t   item,
	input logic             item_valid,
	input logic             item_ready,
	input ssd_pkg::result_t result,
	input logic             result_valid,
	input logic             result_ready
);

	import ssd_pkg::*;

	// a stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.stitch_kind == SkStop) |-> (result.dx == 16'sd0) &&
		(result.dy == 16'sd0))
		else $error("colour stop with nonzero move");

	// a stitch or trim is always the final result of its byte
	a_move_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.stitch_kind != SkStop) |-> result.last)
		else $error("move result not marked last");

	// a count load on an idle output never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.kind == ItemLoad) && !result_valid
		|=> !result_valid)
		else $error("result after count load");

endmodule

bind stitch_stream_decoder ssd_checker u_ssd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item        (item),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result      (result),
	.result_valid(result_valid),
	.result_ready(result_ready)
);
